[hdl/trp_pkg.sv]
// ----------------------------------------------------------------------------
// trp_pkg
// Shared constants, tables and types of the tone row sine player.
// ----------------------------------------------------------------------------
package trp_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_RATE_HZ   = 44100;
  localparam int ROW_LENGTH       = 12;

  // phase bits that select a table entry
  localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);

  // configuration register reset values
  localparam logic [47:0] TONE_ROW_RST = 48'd205163983024656;
  localparam logic [15:0] SPT_RST      = 16'd3675;
  localparam logic [15:0] GAIN_RST     = 16'd16384;

  // polynomial coefficients of the quarter sine, Q15
  localparam logic [11:0] C_A = 12'd2320;
  localparam logic [14:0] C_B = 15'd21024;
  localparam logic [15:0] C_C = 16'd51472;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_TONE_ROW = 2'd0,
    REG_SPT      = 2'd1,
    REG_GAIN     = 2'd2
  } reg_idx_t;

  // C4 * 2^(n/12) in Q16 Hz
  localparam logic [31:0] FREQ_Q16 [16] = '{
    32'd17145893, 32'd18165441, 32'd19245614, 32'd20390018,
    32'd21602472, 32'd22887021, 32'd24247954, 32'd25689813,
    32'd27217409, 32'd28835840, 32'd30550508, 32'd32367136,
    32'd34291786, 32'd36330882, 32'd38491228, 32'd40780036
  };

  // phase increment per sample, rounded, evaluated at elaboration only
  function automatic logic [31:0] phase_inc(input logic [31:0] freq);
    logic [47:0] num;
    num = {freq, 16'h0000} + 48'(SAMPLE_RATE_HZ / 2);
    return 32'(num / 48'(SAMPLE_RATE_HZ));
  endfunction

  localparam logic [31:0] PHASE_INC [16] = '{
    phase_inc(FREQ_Q16[0]),  phase_inc(FREQ_Q16[1]),
    phase_inc(FREQ_Q16[2]),  phase_inc(FREQ_Q16[3]),
    phase_inc(FREQ_Q16[4]),  phase_inc(FREQ_Q16[5]),
    phase_inc(FREQ_Q16[6]),  phase_inc(FREQ_Q16[7]),
    phase_inc(FREQ_Q16[8]),  phase_inc(FREQ_Q16[9]),
    phase_inc(FREQ_Q16[10]), phase_inc(FREQ_Q16[11]),
    phase_inc(FREQ_Q16[12]), phase_inc(FREQ_Q16[13]),
    phase_inc(FREQ_Q16[14]), phase_inc(FREQ_Q16[15])
  };

  typedef struct packed {
    logic [47:0] tone_row;
    logic [15:0] samples_per_tone;
    logic [15:0] gain;
  } cfg_t;

  typedef struct packed {
    logic       neg;
    logic [3:0] tone_position;
    logic       last_of_row;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [15:0] u;
  } item_t;

endpackage

[hdl/tone_row_sine_player_unit.sv]
// ----------------------------------------------------------------------------
// tone_row_sine_player_unit
// Plays a twelve-tone row as sine tones by direct digital synthesis.
// ----------------------------------------------------------------------------
//  channel  direction  handshake         payload
//  in_      input      valid / stall     tick
//  out_     output     valid / stall     sample, tone_position, last_of_row
//  cfg      input      apb write / read  tone_row, samples_per_tone, gain
//
//  one transfer is accepted per cycle while in_stall is low; a tick's sample
//  passes the input register and the five multiplier stages of the sine and
//  gain path, and out_valid rises once it is in the last of them
//  rst_n is synchronous; it clears counters, phase and pipeline valids and
//  loads the register defaults
//  out_stall holds the output; the pipeline keeps taking ticks until all
//  stages are full, then in_stall rises
// ----------------------------------------------------------------------------
module tone_row_sine_player_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_tick,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_sample,
  output logic [3:0]          out_tone_position,
  output logic                out_last_of_row,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  trp_pkg::cfg_t  cfg;
  trp_pkg::item_t item;
  logic           item_valid;
  logic           sine_stall;

  assign in_stall = sine_stall;

  trp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (sine_stall),
    .in_tick    (in_tick),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item)
  );

  trp_sine u_sine (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .item              (item),
    .gain              (cfg.gain),
    .stall             (sine_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_tone_position (out_tone_position),
    .out_last_of_row   (out_last_of_row)
  );

endmodule

[hdl/trp_cfg.sv]
// ----------------------------------------------------------------------------
// trp_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module trp_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output trp_pkg::cfg_t       cfg
);

  logic [47:0] tone_row_r;
  logic [15:0] spt_r;
  logic [15:0] gain_r;
  logic        wr_en;
  trp_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = trp_pkg::reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_row_r <= trp_pkg::TONE_ROW_RST;
      spt_r      <= trp_pkg::SPT_RST;
      gain_r     <= trp_pkg::GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        trp_pkg::REG_TONE_ROW: tone_row_r <= pwdata[47:0];
        trp_pkg::REG_SPT:      spt_r      <= pwdata[15:0];
        trp_pkg::REG_GAIN:     gain_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      trp_pkg::REG_TONE_ROW: prdata = {16'h0000, tone_row_r};
      trp_pkg::REG_SPT:      prdata = {48'h0, spt_r};
      trp_pkg::REG_GAIN:     prdata = {48'h0, gain_r};
      default:               prdata = 64'h0;
    endcase
  end

  assign cfg.tone_row         = tone_row_r;
  assign cfg.samples_per_tone = spt_r;
  assign cfg.gain             = gain_r;

endmodule

[hdl/trp_seq.sv]
// ----------------------------------------------------------------------------
// trp_seq
// Tone sequencer: phase accumulator, sample and tone counters, quadrant fold.
// ----------------------------------------------------------------------------
module trp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_tick,
  input  trp_pkg::cfg_t       cfg,
  output logic                item_valid,
  output trp_pkg::item_t      item
);

  logic [31:0] phase_r, phase_nxt;
  logic [3:0]  tone_r, tone_nxt;
  logic [15:0] count_r, count_nxt;
  logic        acc;
  logic [3:0]  pc;
  logic [16:0] count_inc;
  logic        tone_end;
  logic        row_end;
  logic [15:0] pos;
  logic [14:0] u0;

  assign acc        = in_valid && !in_stall && in_tick;
  assign item_valid = in_valid && in_tick;

  assign pc        = cfg.tone_row[{tone_r, 2'b00} +: 4];
  assign count_inc = {1'b0, count_r} + 17'd1;
  assign tone_end  = count_inc >= {1'b0, cfg.samples_per_tone};
  assign row_end   = ({1'b0, tone_r} + 5'd1) >= 5'(trp_pkg::ROW_LENGTH);

  always_comb begin
    phase_nxt = phase_r + trp_pkg::PHASE_INC[pc];
    count_nxt = count_inc[15:0];
    tone_nxt  = tone_r;
    if (tone_end) begin
      phase_nxt = 32'd0;
      count_nxt = 16'd0;
      tone_nxt  = row_end ? 4'd0 : tone_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 32'd0;
      tone_r  <= 4'd0;
      count_r <= 16'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      tone_r  <= tone_nxt;
      count_r <= count_nxt;
    end
  end

  // table angle in Q16 turns, folded into the first quadrant
  assign pos = {phase_r[31 -: trp_pkg::TBL_BITS], {(16 - trp_pkg::TBL_BITS){1'b0}}};
  assign u0  = {pos[13:0], 1'b0};

  assign item.u                  = pos[14] ? (16'd32768 - {1'b0, u0}) : {1'b0, u0};
  assign item.meta.neg           = pos[15];
  assign item.meta.tone_position = tone_r;
  assign item.meta.last_of_row   = tone_end && row_end;

`ifndef SYNTHESIS
  a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
    tone_r < 4'(trp_pkg::ROW_LENGTH))
    else $error("tone index out of row");

  a_tone_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && tone_end) |=> (phase_r == 32'd0 && count_r == 16'd0))
    else $error("phase or count not cleared at tone end");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && item.meta.last_of_row) |=> (tone_r == 4'd0))
    else $error("row did not wrap after last sample");
`endif

endmodule

[hdl/trp_sine.sv]
// ----------------------------------------------------------------------------
// trp_sine
// Quarter sine polynomial, gain and saturation as a stallable pipeline.
// ----------------------------------------------------------------------------
module trp_sine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  trp_pkg::item_t      item,
  input  logic [15:0]         gain,
  output logic                stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_sample,
  output logic [3:0]          out_tone_position,
  output logic                out_last_of_row
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

  trp_pkg::meta_t m1_r, m2_r, m3_r, m4_r, m5_r;
  logic [15:0] u1_r, u2a_r, u3_r, u4_r;
  logic [15:0] sq2_r, sq3_r;
  logic [14:0] t1_r;
  logic [15:0] t2_r;
  logic [15:0] s5_r;

  logic [31:0] p_sq;
  logic [15:0] sq_nxt;
  logic [27:0] p_a;
  logic [14:0] t1_nxt;
  logic [30:0] p_b;
  logic [15:0] t2_nxt;
  logic [31:0] p_c;
  logic [15:0] s_nxt;
  logic [31:0] p_g;
  logic [16:0] mag;
  logic signed [15:0] sample_nxt;

  logic signed [15:0] sample_r;
  logic [3:0]         tone_r;
  logic               last_r;

  // a stage takes new data when it is empty or its contents move on
  assign rdy_o = !ov_r || !out_stall;
  assign rdy5  = !v5_r || rdy_o;
  assign rdy4  = !v4_r || rdy5;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= item_valid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy4)  v4_r <= v3_r;
      if (rdy5)  v5_r <= v4_r;
      if (rdy_o) ov_r <= v5_r;
    end
  end

  // u2 = u*u >> 15
  assign p_sq   = u1_r * u1_r;
  assign sq_nxt = p_sq[30:15];
  // t1 = 21024 - (u2*2320 >> 15)
  assign p_a    = sq2_r * {4'd0, trp_pkg::C_A};
  assign t1_nxt = trp_pkg::C_B - {3'd0, p_a[26:15]};
  // t2 = 51472 - (u2*t1 >> 15)
  assign p_b    = sq3_r * {1'b0, t1_r};
  assign t2_nxt = trp_pkg::C_C - {1'b0, p_b[29:15]};
  // s = u*t2 >> 15
  assign p_c    = u4_r * t2_r;
  assign s_nxt  = p_c[30:15];
  // gain and saturation
  assign p_g    = s5_r * gain;
  assign mag    = p_g[31:15];

  always_comb begin
    if (m5_r.neg) begin
      sample_nxt = (mag > 17'd32768) ? -16'sd32768 : 16'(-{1'b0, mag[15:0]});
    end else begin
      sample_nxt = (mag > 17'd32767) ? 16'sd32767 : $signed(mag[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      u1_r <= item.u;
      m1_r <= item.meta;
    end
    if (rdy2) begin
      u2a_r <= u1_r;
      sq2_r <= sq_nxt;
      m2_r  <= m1_r;
    end
    if (rdy3) begin
      u3_r  <= u2a_r;
      sq3_r <= sq2_r;
      t1_r  <= t1_nxt;
      m3_r  <= m2_r;
    end
    if (rdy4) begin
      u4_r <= u3_r;
      t2_r <= t2_nxt;
      m4_r <= m3_r;
    end
    if (rdy5) begin
      s5_r <= s_nxt;
      m5_r <= m4_r;
    end
    if (rdy_o) begin
      sample_r <= sample_nxt;
      tone_r   <= m5_r.tone_position;
      last_r   <= m5_r.last_of_row;
    end
  end

  assign out_valid         = ov_r;
  assign out_sample        = sample_r;
  assign out_tone_position = tone_r;
  assign out_last_of_row   = last_r;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && ov_r))
    else $error("input stalled with a free stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_stall) |=> ov_r)
    else $error("finished sample lost before output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=>
      (ov_r && $stable(sample_r) && $stable(tone_r) && $stable(last_r)))
    else $error("stalled sample changed");
`endif

endmodule

[tb/tone_row_sine_player_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_row_sine_player_checker
// Watches the tick, sample and register channels of the tone row sine player,
// predicts every sample from its own copy of the oscillator state and
// compares each sample transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tone_row_sine_player_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_tick,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_sample,
  input  logic [3:0]         out_tone_position,
  input  logic               out_last_of_row,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         tone_position;
    logic               last_of_row;
  } tone_sample_t;

  // C4 * 2^(n/12) Hz in Q16
  localparam logic [31:0] PITCH_HZ_Q16 [16] = '{
    32'd17145893, 32'd18165441, 32'd19245614, 32'd20390018,
    32'd21602472, 32'd22887021, 32'd24247954, 32'd25689813,
    32'd27217409, 32'd28835840, 32'd30550508, 32'd32367136,
    32'd34291786, 32'd36330882, 32'd38491228, 32'd40780036
  };

  logic [47:0]  row_q;
  logic [15:0]  spt_q;
  logic [15:0]  gain_q;
  logic [31:0]  phase_q;
  logic [3:0]   tone_q;
  logic [15:0]  count_q;
  logic [3:0]   pitch;
  logic         tone_end;
  int           fail_count = 0;
  tone_sample_t next_rec;
  tone_sample_t want;

  tone_sample_t expected_samples [$];

  function automatic logic [31:0] pitch_step(input logic [3:0] pc);
    logic [63:0] num;
    num = ({32'd0, PITCH_HZ_Q16[pc]} << 16) + 64'(trp_pkg::SAMPLE_RATE_HZ / 2);
    return 32'(num / 64'(trp_pkg::SAMPLE_RATE_HZ));
  endfunction

  // polynomial quarter wave, u and result in Q15
  function automatic logic [16:0] quarter_wave(input logic [16:0] u);
    logic [63:0] u2;
    logic [63:0] t;
    u2 = (64'(u) * 64'(u)) >> 15;
    t  = 64'(trp_pkg::C_B) - ((u2 * 64'(trp_pkg::C_A)) >> 15);
    t  = 64'(trp_pkg::C_C) - ((u2 * t) >> 15);
    return 17'((64'(u) * t) >> 15);
  endfunction

  function automatic logic signed [15:0] synth_sample(input logic [31:0] phase,
                                                      input logic [15:0] g);
    logic [63:0] idx;
    logic [63:0] pos;
    logic [1:0]  quad;
    logic [16:0] u;
    logic [16:0] mag_s;
    logic [33:0] mag;
    idx   = (64'(phase) * 64'(trp_pkg::SINE_TABLE_DEPTH)) >> 32;
    pos   = ((idx * 64'd65536) / 64'(trp_pkg::SINE_TABLE_DEPTH)) & 64'hFFFF;
    quad  = pos[15:14];
    u     = 17'(pos[13:0]) << 1;
    if (quad[0]) begin
      u = 17'd32768 - u;
    end
    mag_s = quarter_wave(u);
    mag   = (34'(mag_s) * 34'(g)) >> 15;
    // second half of the turn is negative, saturate either side
    if (quad[1] && mag_s != 17'd0) begin
      return (mag > 34'd32768) ? 16'h8000 : 16'(34'd0 - mag);
    end
    return (mag > 34'd32767) ? 16'h7FFF : 16'(mag);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_q   = trp_pkg::TONE_ROW_RST;
      spt_q   = trp_pkg::SPT_RST;
      gain_q  = trp_pkg::GAIN_RST;
      phase_q = '0;
      tone_q  = '0;
      count_q = '0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          trp_pkg::REG_TONE_ROW: row_q  = pwdata[47:0];
          trp_pkg::REG_SPT:      spt_q  = pwdata[15:0];
          trp_pkg::REG_GAIN:     gain_q = pwdata[15:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall && in_tick) begin
        pitch    = row_q[tone_q*4 +: 4];
        tone_end = (17'(count_q) + 17'd1) >= 17'(spt_q);
        next_rec.sample        = synth_sample(phase_q, gain_q);
        next_rec.tone_position = tone_q;
        next_rec.last_of_row   = tone_end && (tone_q >= 4'(trp_pkg::ROW_LENGTH - 1));
        expected_samples.push_back(next_rec);
        // sample uses the phase before the step
        phase_q = phase_q + pitch_step(pitch);
        if (tone_end) begin
          count_q = '0;
          phase_q = '0;
          tone_q  = (tone_q >= 4'(trp_pkg::ROW_LENGTH - 1)) ? 4'd0 : tone_q + 4'd1;
        end else begin
          count_q = count_q + 16'd1;
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample transfer with none expected, got sample %0d pos %0d last %0b",
                   $time, out_sample, out_tone_position, out_last_of_row);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want.sample) begin
            $display("%0t: sample expected %0d got %0d",
                     $time, $signed(want.sample), out_sample);
            fail_count++;
          end
          if (out_tone_position !== want.tone_position) begin
            $display("%0t: tone_position expected %0d got %0d",
                     $time, want.tone_position, out_tone_position);
            fail_count++;
          end
          if (out_last_of_row !== want.last_of_row) begin
            $display("%0t: last_of_row expected %0b got %0b",
                     $time, want.last_of_row, out_last_of_row);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_samples.size();
    errors  <= fail_count;
  end

endmodule

[tb/tone_row_sine_player_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_row_sine_player_unit_test
// Drives ticks and register writes into the tone row sine player with random
// gaps and output stalls; a checker beside the block predicts and compares
// every sample and this top gives the verdict.
// ----------------------------------------------------------------------------
module tone_row_sine_player_unit_test;

  localparam int PHASE_ITEMS = 156;
  localparam int SETTLE      = 12;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_tick = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic [3:0]         out_tone_position;
  logic               out_last_of_row;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               idle_en = 1'b1;
  int                 errors;
  int                 pending;

  tone_row_sine_player_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick           (in_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_tone_position (out_tone_position),
    .out_last_of_row   (out_last_of_row),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  tone_row_sine_player_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick           (in_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_tone_position (out_tone_position),
    .out_last_of_row   (out_last_of_row),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .errors            (errors),
    .pending           (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 12);
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // returns at the edge where the tick transfer happened
  task automatic send_tick(input logic t);
    if (idle_en) begin
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_tick  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input trp_pkg::reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [47:0] row, input logic [15:0] spt,
                           input logic [15:0] g);
    write_reg(trp_pkg::REG_TONE_ROW, {16'd0, row});
    write_reg(trp_pkg::REG_SPT, {48'd0, spt});
    write_reg(trp_pkg::REG_GAIN, {48'd0, g});
  endtask

  initial begin
    logic [47:0] row;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults, an empty tick and the zero first sample
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    drain();

    // zero samples per tone acts as one: whole row, wrap and last flag
    configure(48'hFFFF_FFFF_FFFF, 16'd0, 16'hFFFF);
    repeat (13) send_tick(1'b1);
    drain();

    // top pitch class at full gain climbs into saturation
    configure(48'h0000_0000_000F, 16'd24, 16'hFFFF);
    repeat (8) send_tick(1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      row = 48'({$urandom(), $urandom()});
      case (p)
        0: configure(row, 16'd5, 16'hFFFF);
        1: configure(48'hFFFF_FFFF_FFFF, 16'd1, 16'd0);
        2: configure(48'h0, 16'hFFFF, 16'd32768);
        // short tones after a long one: count already past the new length
        3: configure(row, 16'($urandom_range(20, 80)), 16'hFFFF);
        default: configure(row, 16'($urandom_range(1, 60)), 16'($urandom()));
      endcase
      idle_en = (p != 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) begin
          drain();
        end
        send_tick($urandom_range(9) != 0);
      end
      drain();
    end

    idle_en = 1'b1;
    drain();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
hdl/trp_pkg.sv
hdl/trp_cfg.sv
hdl/trp_seq.sv
hdl/trp_sine.sv
hdl/tone_row_sine_player_unit.sv
tb/tone_row_sine_player_checker.sv
tb/tone_row_sine_player_unit_test.sv
